// ----- design/vtp_pkg.sv -----
// Shared types, codes and translation tables of the text console parser.
package vtp_pkg;

	localparam int ESCAPE_DEPTH_DEF = 16;
	localparam int MAX_COLUMNS      = 256;
	localparam int MAX_ROWS         = 128;
	localparam int OFIFO_DEPTH      = 4;

	localparam logic [8:0] COLUMNS_RESET = 9'd80;
	localparam logic [7:0] ROWS_RESET    = 8'd30;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_COLUMNS = 2'd1;
	localparam logic [1:0] REG_ROWS    = 2'd2;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_ESC = 8'h1b;

	localparam logic [2:0] CMD_DRAW   = 3'd0;
	localparam logic [2:0] CMD_SCROLL = 3'd1;
	localparam logic [2:0] CMD_CLEAR  = 3'd2;
	localparam logic [2:0] CMD_REPORT = 3'd3;
	localparam logic [2:0] CMD_SHOW   = 3'd4;
	localparam logic [2:0] CMD_HIDE   = 3'd5;

	localparam logic [1:0] CS_GFX   = 2'd0;
	localparam logic [1:0] CS_UK    = 2'd1;
	localparam logic [1:0] CS_ASCII = 2'd2;

	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_EXEC    = 4'd1;
	localparam logic [3:0] OP_SKIP    = 4'd2;
	localparam logic [3:0] OP_SIGN    = 4'd3;
	localparam logic [3:0] OP_DIGIT   = 4'd4;
	localparam logic [3:0] OP_END_ROW = 4'd5;
	localparam logic [3:0] OP_END_COL = 4'd6;
	localparam logic [3:0] OP_SEP_ROW = 4'd7;
	localparam logic [3:0] OP_SEP_COL = 4'd8;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] glyph;
		logic [8:0] column;
		logic [7:0] row;
		logic       inverse;
		logic       last;
	} result_t;

	typedef struct packed {
		logic       accept;
		logic [3:0] op;
	} ctl_t;

	typedef struct packed {
		logic pos_start;
		logic at_space;
		logic at_sign;
		logic at_digit;
		logic semi_ok;
	} stat_t;

	localparam logic [7:0] GFX_ROM [256] = '{
		8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,
		8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,8'h17,8'h18,8'h19,8'h1a,8'h1b,8'h1c,8'h1d,8'h1e,8'h1f,
		8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h1a,8'h1b,8'h18,8'h19,8'h2f,
		8'hdb,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3a,8'h3b,8'h3c,8'h3d,8'h3e,8'h3f,
		8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,
		8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,8'h58,8'h59,8'h5a,8'h5b,8'h5c,8'h5d,8'h5e,8'ha0,
		8'h00,8'hb1,8'h00,8'h00,8'h00,8'h00,8'hb0,8'hb1,8'hb0,8'h00,8'hd9,8'hbf,8'hda,8'hc0,8'hc5,8'h00,
		8'h00,8'hc4,8'h00,8'h00,8'hc3,8'hb4,8'hc1,8'hc2,8'hb3,8'hf3,8'hf2,8'he3,8'h00,8'h9c,8'hb7,8'h7f,
		8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,
		8'h90,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,
		8'ha0,8'ha1,8'h9b,8'h9c,8'ha4,8'h9d,8'ha6,8'h15,8'ha8,8'ha9,8'ha6,8'hab,8'haa,8'had,8'hae,8'haf,
		8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'h14,8'hb7,8'hb8,8'hb9,8'ha7,8'haf,8'hac,8'hab,8'hbe,8'ha8,
		8'hc0,8'hc1,8'hc2,8'hc3,8'h8e,8'h8f,8'h92,8'h80,8'hc8,8'h90,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,
		8'hd0,8'ha5,8'hd2,8'hd3,8'hd4,8'hd5,8'h99,8'hd7,8'hd8,8'hd9,8'hda,8'hdb,8'h9a,8'hdd,8'hde,8'hdf,
		8'h85,8'ha0,8'h83,8'he3,8'h84,8'h86,8'h91,8'h87,8'h8a,8'h82,8'h88,8'h89,8'h8d,8'ha1,8'h8c,8'h8b,
		8'hf0,8'ha4,8'h95,8'ha2,8'h93,8'hf5,8'h94,8'hf6,8'hf8,8'h97,8'ha3,8'h96,8'h81,8'hfd,8'hfe,8'h98
	};

	// UK set above 0x7f; lower codes pass unchanged
	localparam logic [7:0] UK_HIGH_ROM [128] = '{
		8'h80,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,
		8'h90,8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,
		8'h5f,8'ha1,8'h9b,8'h7d,8'ha4,8'h9d,8'ha6,8'h15,8'ha8,8'ha9,8'ha6,8'hab,8'haa,8'had,8'hae,8'haf,
		8'h66,8'h67,8'hb2,8'hb3,8'hb4,8'hb5,8'h14,8'h7e,8'hb8,8'hb9,8'ha7,8'haf,8'hac,8'hab,8'hbe,8'ha8,
		8'hc0,8'hc1,8'hc2,8'hc3,8'h8e,8'h8f,8'h92,8'h80,8'hc8,8'h90,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,
		8'hd0,8'ha5,8'hd2,8'hd3,8'hd4,8'hd5,8'h99,8'hd7,8'hd8,8'hd9,8'hda,8'hdb,8'h9a,8'hdd,8'hde,8'hdf,
		8'h85,8'ha0,8'h83,8'he3,8'h84,8'h86,8'h91,8'h87,8'h8a,8'h82,8'h88,8'h89,8'h8d,8'ha1,8'h8c,8'h8b,
		8'hf0,8'ha4,8'h95,8'ha2,8'h93,8'hf5,8'h94,8'hf6,8'hf8,8'h97,8'ha3,8'h96,8'h81,8'hfd,8'hfe,8'h98
	};

	function automatic logic [7:0] glyph_for(logic [1:0] cs, logic [7:0] c);
		logic [7:0] g;
		unique case (cs)
			CS_GFX: g = GFX_ROM[c];
			CS_UK: g = c[7] ? UK_HIGH_ROM[c[6:0]] : c;
			default: g = c;
		endcase
		return g;
	endfunction

	function automatic result_t cmd_only(logic [2:0] cmd);
		result_t r;
		r = '0;
		r.command = cmd;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

// ----- design/vtp_ofifo.sv -----
// Four-word result queue between the datapath and the output stream.
module vtp_ofifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  vtp_pkg::result_t push_d0,
	input  vtp_pkg::result_t push_d1,
	input  logic             pop,
	output logic             valid,
	output vtp_pkg::result_t head,
	output logic [2:0]       count
);
	import vtp_pkg::*;

	localparam int AW = $clog2(OFIFO_DEPTH);

	result_t        mem_q [OFIFO_DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [2:0]     cnt_q;
	logic           do_pop;

	assign do_pop = pop && (cnt_q != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + AW'(push_n);
			rp_q <= rp_q + AW'(do_pop);
			cnt_q <= cnt_q + 3'(push_n) - 3'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wp_q] <= push_d0;
		if (push_n == 2'd2) mem_q[wp_q + AW'(1)] <= push_d1;
	end

	assign valid = cnt_q != 3'd0;
	assign head = mem_q[rp_q];
	assign count = cnt_q;

endmodule

// ----- design/vtp_ctrl.sv -----
// Controller: sequences execution and the cursor position scan.
module vtp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           enable,
	input  logic           room,
	input  vtp_pkg::stat_t stat,
	output logic           ready,
	output vtp_pkg::ctl_t  ctl
);
	import vtp_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_WS   = 3'd2;
	localparam logic [2:0] ST_DIG  = 3'd3;
	localparam logic [2:0] ST_SEP  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       col_q, col_d;

	assign ready = (state_q == ST_IDLE) && room;
	assign ctl.accept = in_valid && ready;

	always_comb begin
		state_d = state_q;
		col_d = col_q;
		ctl.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.accept && enable) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				ctl.op = OP_EXEC;
				col_d = 1'b0;
				state_d = stat.pos_start ? ST_WS : ST_IDLE;
			end
			ST_WS: begin
				if (stat.at_space) begin
					ctl.op = OP_SKIP;
				end else begin
					if (stat.at_sign) ctl.op = OP_SIGN;
					state_d = ST_DIG;
				end
			end
			ST_DIG: begin
				if (stat.at_digit) begin
					ctl.op = OP_DIGIT;
				end else begin
					ctl.op = col_q ? OP_END_COL : OP_END_ROW;
					state_d = ST_SEP;
				end
			end
			ST_SEP: begin
				ctl.op = col_q ? OP_SEP_COL : OP_SEP_ROW;
				if (!col_q && stat.semi_ok) begin
					col_d = 1'b1;
					state_d = ST_WS;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q <= col_d;
		end
	end

endmodule

// ----- design/vtp_dpath.sv -----
// Datapath: cursor state, escape store, number scan and result build.
module vtp_dpath #(
	parameter int ESCAPE_DEPTH = vtp_pkg::ESCAPE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  vtp_pkg::ctl_t    ctl,
	input  logic [7:0]       char_in,
	input  logic [8:0]       cfg_columns,
	input  logic [7:0]       cfg_rows,
	output vtp_pkg::stat_t   stat,
	output logic [1:0]       push_n,
	output vtp_pkg::result_t push_d0,
	output vtp_pkg::result_t push_d1
);
	import vtp_pkg::*;

	localparam int SD = ESCAPE_DEPTH - 1;
	localparam int CW = $clog2(ESCAPE_DEPTH + 1);
	localparam int IW = $clog2(SD);

	localparam logic [3:0] K_ORD     = 4'd0;
	localparam logic [3:0] K_STORE   = 4'd1;
	localparam logic [3:0] K_SAVE    = 4'd2;
	localparam logic [3:0] K_REST    = 4'd3;
	localparam logic [3:0] K_CSET    = 4'd4;
	localparam logic [3:0] K_CLEAR   = 4'd5;
	localparam logic [3:0] K_HIDE    = 4'd6;
	localparam logic [3:0] K_SHOW    = 4'd7;
	localparam logic [3:0] K_INV_ON  = 4'd8;
	localparam logic [3:0] K_INV_OFF = 4'd9;
	localparam logic [3:0] K_REPORT  = 4'd10;
	localparam logic [3:0] K_POS     = 4'd11;

	logic [7:0]    char_q;
	logic [7:0]    cur_col_q, sav_col_q;
	logic [6:0]    cur_row_q, sav_row_q;
	logic [1:0]    cset_q;
	logic          inv_q;
	logic [CW-1:0] cnt_q, nlen_q, p_q, start_q;
	logic [7:0]    store_q [SD];
	logic [15:0]   val_q;
	logic          neg_q, dig_q;
	logic [7:0]    y_q;
	logic [8:0]    x_q;

	logic          esc_act;
	logic [7:0]    lead;
	logic [3:0]    kind;
	logic [CW-1:0] wr_cnt;

	assign esc_act = (cnt_q != '0) && (cnt_q < CW'(ESCAPE_DEPTH));
	assign lead = (cnt_q == CW'(1)) ? char_q : store_q[0];
	assign wr_cnt = cnt_q - CW'(1);

	always_comb begin
		kind = K_ORD;
		if (esc_act) begin
			if (lead == "7") kind = K_SAVE;
			else if (lead == "8") kind = K_REST;
			else if (lead == "(") kind = (cnt_q == CW'(1)) ? K_STORE : K_CSET;
			else if (lead == "[") begin
				if (cnt_q == CW'(1)) begin
					kind = K_STORE;
				end else begin
					unique case (char_q)
						"J": kind = (cnt_q == CW'(3) && store_q[1] == "2") ? K_CLEAR : K_ORD;
						"l", "h": begin
							if (cnt_q == CW'(5) && store_q[1] == "?" && store_q[2] == "2" &&
							    store_q[3] == "5")
								kind = (char_q == "l") ? K_HIDE : K_SHOW;
							else
								kind = K_ORD;
						end
						"m": begin
							if (cnt_q == CW'(3) && store_q[1] == "7") kind = K_INV_ON;
							else if (cnt_q == CW'(4) && store_q[1] == "2" && store_q[2] == "7")
								kind = K_INV_OFF;
							else kind = K_ORD;
						end
						"n": kind = (cnt_q == CW'(3) && store_q[1] == "6") ? K_REPORT : K_ORD;
						"H": kind = K_POS;
						default: kind = K_STORE;
					endcase
				end
			end
		end
	end

	// scan byte at the position pointer
	logic [7:0] scan_b;
	logic       scan_v;
	assign scan_v = p_q < nlen_q;
	assign scan_b = (p_q < CW'(SD)) ? store_q[p_q[IW-1:0]] : 8'h00;

	assign stat.pos_start = (ctl.op == OP_EXEC) && (kind == K_POS);
	assign stat.at_space = scan_v && (scan_b == 8'h20 || (scan_b >= 8'h09 && scan_b <= 8'h0d));
	assign stat.at_sign = scan_v && (scan_b == "+" || scan_b == "-");
	assign stat.at_digit = scan_v && scan_b >= "0" && scan_b <= "9";
	assign stat.semi_ok = scan_v && scan_b == ";";

	logic h_ok;
	assign h_ok = scan_v && scan_b == "H";

	// ordinary byte
	logic [8:0] col_inc, o_col;
	logic [7:0] row_inc, o_row;
	logic       o_draw, o_esc, o_scroll;

	assign col_inc = {1'b0, cur_col_q} + 9'd1;
	assign row_inc = {1'b0, cur_row_q} + 8'd1;

	always_comb begin
		o_col = {1'b0, cur_col_q};
		o_row = {1'b0, cur_row_q};
		o_draw = 1'b0;
		o_esc = 1'b0;
		priority if (char_q == CH_CR) begin
			o_col = '0;
		end else if (char_q == CH_LF) begin
			o_col = '0;
			o_row = row_inc;
		end else if (char_q == CH_BS) begin
			if (cur_col_q != 8'd0) begin
				o_col = {1'b0, cur_col_q} - 9'd1;
			end else if (cur_row_q != 7'd0) begin
				o_row = {1'b0, cur_row_q} - 8'd1;
				o_col = cfg_columns - 9'd1;
			end
		end else if (char_q == CH_ESC) begin
			o_esc = 1'b1;
		end else begin
			o_draw = 1'b1;
			if (col_inc >= cfg_columns) begin
				o_col = '0;
				o_row = row_inc;
			end else begin
				o_col = col_inc;
			end
		end
		o_scroll = o_row >= cfg_rows;
		if (o_scroll) o_row = cfg_rows - 8'd1;
	end

	logic do_ord;
	assign do_ord = (ctl.op == OP_EXEC && kind == K_ORD) ||
	                (ctl.op == OP_SEP_ROW && !stat.semi_ok) ||
	                (ctl.op == OP_SEP_COL && !h_ok);

	result_t draw_r, rep_r;
	always_comb begin
		draw_r.command = CMD_DRAW;
		draw_r.glyph = glyph_for(cset_q, char_q);
		draw_r.column = {1'b0, cur_col_q};
		draw_r.row = {1'b0, cur_row_q};
		draw_r.inverse = inv_q;
		draw_r.last = !o_scroll;
		rep_r = cmd_only(CMD_REPORT);
		rep_r.column = col_inc;
		rep_r.row = row_inc;
	end

	always_comb begin
		push_n = 2'd0;
		push_d0 = cmd_only(CMD_SCROLL);
		push_d1 = cmd_only(CMD_SCROLL);
		if (do_ord) begin
			if (o_draw) begin
				push_d0 = draw_r;
				push_n = o_scroll ? 2'd2 : 2'd1;
			end else if (o_scroll) begin
				push_n = 2'd1;
			end
		end else if (ctl.op == OP_EXEC) begin
			unique case (kind)
				K_CLEAR: begin push_n = 2'd1; push_d0 = cmd_only(CMD_CLEAR); end
				K_HIDE: begin push_n = 2'd1; push_d0 = cmd_only(CMD_HIDE); end
				K_SHOW: begin push_n = 2'd1; push_d0 = cmd_only(CMD_SHOW); end
				K_REPORT: begin push_n = 2'd1; push_d0 = rep_r; end
				default: push_n = 2'd0;
			endcase
		end
	end

	// number clamp to [1, limit]
	logic [8:0]  lim, clamped;
	logic [19:0] acc;
	assign lim = (ctl.op == OP_END_ROW) ? {1'b0, cfg_rows} : cfg_columns;
	always_comb begin
		if ((neg_q && dig_q) || !dig_q || val_q == 16'd0) clamped = 9'd1;
		else if (val_q > {7'd0, lim}) clamped = lim;
		else clamped = val_q[8:0];
	end
	assign acc = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} + {16'd0, scan_b[3:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			sav_col_q <= '0;
			sav_row_q <= '0;
			cset_q <= CS_ASCII;
			inv_q <= 1'b0;
			cnt_q <= '0;
			p_q <= '0;
			start_q <= '0;
			neg_q <= 1'b0;
			dig_q <= 1'b0;
		end else begin
			if (do_ord) begin
				cur_col_q <= o_col[7:0];
				cur_row_q <= o_row[6:0];
				cnt_q <= o_esc ? CW'(1) : '0;
			end else begin
				unique case (ctl.op)
					OP_EXEC: begin
						unique case (kind)
							K_STORE: cnt_q <= cnt_q + CW'(1);
							K_SAVE: begin
								sav_col_q <= cur_col_q;
								sav_row_q <= cur_row_q;
								cnt_q <= '0;
							end
							K_REST: begin
								cur_col_q <= sav_col_q;
								cur_row_q <= sav_row_q;
								cnt_q <= '0;
							end
							K_CSET: begin
								if (char_q == "0") cset_q <= CS_GFX;
								else if (char_q == "A") cset_q <= CS_UK;
								else if (char_q == "B") cset_q <= CS_ASCII;
								cnt_q <= '0;
							end
							K_CLEAR: begin
								cur_col_q <= '0;
								cur_row_q <= '0;
								cnt_q <= '0;
							end
							K_INV_ON: begin inv_q <= 1'b1; cnt_q <= '0; end
							K_INV_OFF: begin inv_q <= 1'b0; cnt_q <= '0; end
							K_POS: begin
								p_q <= CW'(1);
								start_q <= CW'(1);
								neg_q <= 1'b0;
								dig_q <= 1'b0;
								cnt_q <= '0;
							end
							default: cnt_q <= '0;
						endcase
					end
					OP_SKIP: p_q <= p_q + CW'(1);
					OP_SIGN: begin
						neg_q <= scan_b == "-";
						p_q <= p_q + CW'(1);
					end
					OP_DIGIT: begin
						dig_q <= 1'b1;
						p_q <= p_q + CW'(1);
					end
					OP_END_ROW, OP_END_COL: begin
						// no digits: rewind past any white space and sign
						if (!dig_q) p_q <= start_q;
					end
					OP_SEP_ROW: begin
						p_q <= p_q + CW'(1);
						start_q <= p_q + CW'(1);
						neg_q <= 1'b0;
						dig_q <= 1'b0;
					end
					OP_SEP_COL: begin
						cur_col_q <= 8'(x_q - 9'd1);
						cur_row_q <= 7'(y_q - 8'd1);
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) char_q <= char_in;
		if (ctl.op == OP_EXEC && esc_act) store_q[wr_cnt[IW-1:0]] <= char_q;
		if (ctl.op == OP_EXEC) begin
			nlen_q <= cnt_q;
			val_q <= '0;
		end
		if (ctl.op == OP_SEP_ROW) val_q <= '0;
		if (ctl.op == OP_DIGIT) val_q <= (acc > 20'd65535) ? 16'hffff : acc[15:0];
		if (ctl.op == OP_END_ROW) y_q <= clamped[7:0];
		if (ctl.op == OP_END_COL) x_q <= clamped;
	end

endmodule

// ----- design/vt100_text_console_parser_unit.sv -----
// VT100 console parser: one character per word in, draw and control command words out.
// Each accepted character is taken in the idle state and then executed, when its command
// words enter a four-word output queue; a cursor position sequence (ESC [ row ; col H)
// then scans the bytes held in the escape store after ESC one at a time, through the
// white-space, digit and separator states. A new character is taken once execution is
// done and the queue has room for two words, so input continues while results wait
// downstream. Registers: enable at 0x0, text columns at 0x4 (clamped to 1..256),
// text rows at 0x8 (1..128).
module vt100_text_console_parser_unit #(
	parameter int ESCAPE_DEPTH = vtp_pkg::ESCAPE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] glyph_code, [16:8] column, [24:17] row,
	                               // [25] inverse, [31:26] zero
	output logic [2:0]  m_tuser,   // [2:0] command
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vtp_pkg::*;

	logic       enable_q;
	logic [8:0] columns_q;
	logic [7:0] rows_q;
	logic       cfg_wr;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			columns_q <= COLUMNS_RESET;
			rows_q <= ROWS_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_COLUMNS: begin
					if (pwdata[8:0] == 9'd0) columns_q <= 9'd1;
					else if (pwdata[8:0] > 9'(MAX_COLUMNS)) columns_q <= 9'(MAX_COLUMNS);
					else columns_q <= pwdata[8:0];
				end
				REG_ROWS: begin
					if (pwdata[7:0] == 8'd0) rows_q <= 8'd1;
					else if (pwdata[7:0] > 8'(MAX_ROWS)) rows_q <= 8'(MAX_ROWS);
					else rows_q <= pwdata[7:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_COLUMNS: prdata = {23'd0, columns_q};
			REG_ROWS: prdata = {24'd0, rows_q};
			default: prdata = '0;
		endcase
	end

	ctl_t       ctl;
	stat_t      stat;
	logic [1:0] push_n;
	result_t    push_d0, push_d1, head;
	logic [2:0] fifo_cnt;

	vtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.enable   (enable_q),
		.room     (fifo_cnt <= 3'(OFIFO_DEPTH - 2)),
		.stat     (stat),
		.ready    (s_tready),
		.ctl      (ctl)
	);

	vtp_dpath #(.ESCAPE_DEPTH(ESCAPE_DEPTH)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.char_in     (s_tdata),
		.cfg_columns (columns_q),
		.cfg_rows    (rows_q),
		.stat        (stat),
		.push_n      (push_n),
		.push_d0     (push_d0),
		.push_d1     (push_d1)
	);

	vtp_ofifo u_ofifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_n  (push_n),
		.push_d0 (push_d0),
		.push_d1 (push_d1),
		.pop     (m_tready),
		.valid   (m_tvalid),
		.head    (head),
		.count   (fifo_cnt)
	);

	assign m_tdata = {6'd0, head.inverse, head.row, head.column, head.glyph};
	assign m_tuser = head.command;
	assign m_tlast = head.last;

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> fifo_cnt <= 3'(OFIFO_DEPTH - 2))
		else $error("input ready without room for two words");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && enable_q) |=> !s_tready)
		else $error("ready again before the character was executed");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid == (fifo_cnt != 3'd0))
		else $error("output valid disagrees with queue count");

endmodule

// ----- bench/tb_vt100_text_console_parser_unit.sv -----
// Self-checking bench for the VT100 console parser: directed table, then random text and escapes.
`timescale 1ns / 100ps

module tb_vt100_text_console_parser_unit;
	import vtp_pkg::*;

	localparam int ESC_DEPTH = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [7:0] ch;
		bit         typed;
		result_t    want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	vt100_text_console_parser_unit uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// console state as the parser should hold it
	bit         en;
	int         n_cols, n_rows;
	int         cur_col, cur_row, sav_col, sav_row;
	logic [1:0] char_set;
	bit         inv_mode;
	int         esc_cnt;
	logic [7:0] esc_buf [ESC_DEPTH];

	result_t    step_out[$];
	result_t    expected_cmds[$];

	int  mismatches, words_seen, chars_sent, idle_words;
	int  cmd_seen [6];
	bit  use_gaps;
	bit  hold_req;
	bit  failed;

	function automatic logic [7:0] translate(logic [7:0] c);
		if (char_set == CS_GFX) return GFX_ROM[c];
		if (char_set == CS_UK) return c[7] ? UK_HIGH_ROM[c[6:0]] : c;
		return c;
	endfunction

	function automatic void put(logic [2:0] cmd, logic [7:0] g, int col, int row, bit inv);
		result_t r;
		r.command = cmd;
		r.glyph = g;
		r.column = col[8:0];
		r.row = row[7:0];
		r.inverse = inv;
		r.last = 1'b0;
		step_out.push_back(r);
	endfunction

	function automatic bit seq_is(string lit, int n);
		if (lit.len() != n) return 0;
		for (int i = 0; i < n; i++)
			if (esc_buf[i] != lit[i]) return 0;
		return 1;
	endfunction

	function automatic bit is_blank(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
	endfunction

	// one signed decimal field of a position sequence, clamped to 1..lim
	function automatic int scan_number(inout int pos, input int n, input int lim);
		int p, v, digits;
		bit neg;
		p = pos;
		v = 0;
		digits = 0;
		neg = 0;
		while (p < n && is_blank(esc_buf[p])) p++;
		if (p < n && (esc_buf[p] == "+" || esc_buf[p] == "-")) begin
			neg = esc_buf[p] == "-";
			p++;
		end
		while (p < n && esc_buf[p] >= "0" && esc_buf[p] <= "9") begin
			v = v * 10 + (esc_buf[p] - "0");
			if (v > 65535) v = 65535;
			p++;
			digits++;
		end
		if (digits == 0) begin
			p = pos;
			v = 0;
			neg = 0;
		end
		pos = p;
		if (neg || v < 1) return 1;
		return v > lim ? lim : v;
	endfunction

	function automatic bit csi_done(logic [7:0] c, int n);
		int p, y, x;
		case (c)
			"J": begin
				if (!seq_is("[2J", n)) return 0;
				cur_col = 0;
				cur_row = 0;
				put(CMD_CLEAR, 0, 0, 0, 0);
				return 1;
			end
			"l": begin
				if (!seq_is("[?25l", n)) return 0;
				put(CMD_HIDE, 0, 0, 0, 0);
				return 1;
			end
			"h": begin
				if (!seq_is("[?25h", n)) return 0;
				put(CMD_SHOW, 0, 0, 0, 0);
				return 1;
			end
			"H": begin
				p = 1;
				y = scan_number(p, n, n_rows);
				if (p >= n || esc_buf[p] != ";") return 0;
				p++;
				x = scan_number(p, n, n_cols);
				if (p >= n || esc_buf[p] != "H") return 0;
				cur_col = x - 1;
				cur_row = y - 1;
				return 1;
			end
			"m": begin
				if (seq_is("[7m", n)) begin
					inv_mode = 1;
					return 1;
				end
				if (seq_is("[27m", n)) begin
					inv_mode = 0;
					return 1;
				end
				return 0;
			end
			"n": begin
				if (!seq_is("[6n", n)) return 0;
				put(CMD_REPORT, 0, cur_col + 1, cur_row + 1, 0);
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic void plain_char(logic [7:0] c);
		esc_cnt = 0;
		if (c == CH_CR) begin
			cur_col = 0;
		end else if (c == CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (c == CH_BS) begin
			if (cur_col > 0) begin
				cur_col--;
			end else if (cur_row > 0) begin
				cur_row--;
				cur_col = n_cols - 1;
			end
		end else if (c == CH_ESC) begin
			esc_cnt = 1;
		end else begin
			put(CMD_DRAW, translate(c), cur_col, cur_row, inv_mode);
			cur_col++;
			if (cur_col >= n_cols) begin
				cur_col = 0;
				cur_row++;
			end
		end
		if (cur_row >= n_rows) begin
			put(CMD_SCROLL, 0, 0, 0, 0);
			cur_row = n_rows - 1;
		end
	endfunction

	// commands one character should produce, left in step_out
	function automatic void console_step(logic [7:0] c);
		int n;
		logic [7:0] lead;
		bit done;
		step_out.delete();
		if (!en) return;
		done = 0;
		if (esc_cnt != 0 && esc_cnt < ESC_DEPTH) begin
			n = esc_cnt;
			esc_buf[n - 1] = c;
			esc_cnt = n + 1;
			lead = esc_buf[0];
			done = 1;
			if (lead == "7") begin
				sav_col = cur_col;
				sav_row = cur_row;
				esc_cnt = 0;
			end else if (lead == "8") begin
				cur_col = sav_col;
				cur_row = sav_row;
				esc_cnt = 0;
			end else if (lead == "(") begin
				if (n >= 2) begin
					if (esc_buf[1] == "0") char_set = CS_GFX;
					else if (esc_buf[1] == "A") char_set = CS_UK;
					else if (esc_buf[1] == "B") char_set = CS_ASCII;
					esc_cnt = 0;
				end
			end else if (lead == "[") begin
				if (n >= 2) begin
					if (csi_done(c, n)) esc_cnt = 0;
					else if (c == "J" || c == "l" || c == "h" || c == "H" || c == "m" ||
						c == "n") done = 0;
				end
			end else begin
				done = 0;
			end
		end
		if (!done) plain_char(c);
		if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
	endfunction

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENABLE: en = val[0];
			REG_COLUMNS: n_cols = val[8:0] < 1 ? 1 : (val[8:0] > MAX_COLUMNS ? MAX_COLUMNS : val[8:0]);
			REG_ROWS: n_rows = val[7:0] < 1 ? 1 : (val[7:0] > MAX_ROWS ? MAX_ROWS : val[7:0]);
			default: ;
		endcase
	endtask

	// offer one character, wait for it to be taken, then predict
	task automatic send_char(logic [7:0] c, bit typed = 0, result_t want = '0);
		int gap;
		gap = use_gaps ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		chars_sent++;
		console_step(c);
		if (!en) idle_words++;
		if (typed) expected_cmds.push_back(want);
		else foreach (step_out[i]) expected_cmds.push_back(step_out[i]);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_cmds.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_num(ref logic [7:0] q[$]);
		int k;
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
			q.push_back($urandom_range(0, 1) ? 8'h20 : 8'h09);
		k = $urandom_range(0, 5);
		if (k == 0) q.push_back("-");
		else if (k == 1) q.push_back("+");
		k = $urandom_range(0, 9) == 0 ? $urandom_range(5, 7) : $urandom_range(0, 3);
		repeat (k) q.push_back(8'("0" + $urandom_range(0, 9)));
	endtask

	// one well-formed or deliberately broken piece of console text
	task automatic send_piece();
		logic [7:0] q[$];
		string fixed [6] = '{"[2J", "[?25l", "[?25h", "[7m", "[27m", "[6n"};
		string s;
		int kind;
		kind = $urandom_range(0, 19);
		if (kind < 6) begin
			repeat ($urandom_range(1, 6))
				q.push_back($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(8'h20, 8'h7e)));
		end else if (kind < 9) begin
			q.push_back($urandom_range(0, 2) == 0 ? CH_CR :
				($urandom_range(0, 1) ? CH_LF : CH_BS));
		end else if (kind < 10) begin
			q.push_back(CH_ESC);
			q.push_back($urandom_range(0, 1) ? "7" : "8");
		end else if (kind < 11) begin
			q.push_back(CH_ESC);
			q.push_back("(");
			case ($urandom_range(0, 3))
				0: q.push_back("0");
				1: q.push_back("A");
				2: q.push_back("B");
				default: q.push_back(8'($urandom_range(0, 255)));
			endcase
		end else if (kind < 14) begin
			s = fixed[$urandom_range(0, 5)];
			q.push_back(CH_ESC);
			for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		end else if (kind < 18) begin
			q.push_back(CH_ESC);
			q.push_back("[");
			push_num(q);
			if ($urandom_range(0, 7) != 0) q.push_back(";");
			push_num(q);
			q.push_back($urandom_range(0, 7) != 0 ? "H" : 8'($urandom_range(0, 255)));
		end else begin
			// broken or overlong escape
			q.push_back(CH_ESC);
			if ($urandom_range(0, 1)) q.push_back("[");
			repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
		end
		foreach (q[i]) send_char(q[i]);
	endtask

	// result side
	always @(posedge clk) begin
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got.command = m_tuser;
			got.glyph = m_tdata[7:0];
			got.column = m_tdata[16:8];
			got.row = m_tdata[24:17];
			got.inverse = m_tdata[25];
			got.last = m_tlast;
			words_seen++;
			if (got.command < 6) cmd_seen[got.command]++;
			if (expected_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word cmd=%0d glyph=%h col=%0d row=%0d inv=%0d last=%0d",
						got.command, got.glyph, got.column, got.row, got.inverse, got.last);
			end else begin
				want = expected_cmds.pop_front();
				if (got !== want || m_tdata[31:26] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp cmd=%0d glyph=%h col=%0d row=%0d inv=%0d last=%0d %s",
							want.command, want.glyph, want.column, want.row, want.inverse,
							want.last, "");
					if (mismatches <= 10)
						$display("         got cmd=%0d glyph=%h col=%0d row=%0d inv=%0d last=%0d",
							got.command, got.glyph, got.column, got.row, got.inverse, got.last);
				end
			end
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
			end
			stall = use_gaps ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready) && !hold_req);
		end
	end

	// watchdog on handshake activity
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet = 0;
			else quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", quiet);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic result_t typed_cmd(logic [2:0] cmd, logic [7:0] g, int col, int row);
		result_t r;
		r.command = cmd;
		r.glyph = g;
		r.column = col[8:0];
		r.row = row[7:0];
		r.inverse = 1'b0;
		r.last = 1'b1;
		return r;
	endfunction

	initial begin
		dir_row_t dir[$];
		int cfg_en [7] = '{1, 1, 1, 0, 1, 1, 1};
		int cfg_cols [7] = '{0, 511, 5, 80, 40, 256, 80};
		int cfg_rows [7] = '{0, 255, 3, 30, 10, 1, 30};
		int start;

		en = 0;
		n_cols = COLUMNS_RESET;
		n_rows = ROWS_RESET;
		cur_col = 0;
		cur_row = 0;
		sav_col = 0;
		sav_row = 0;
		char_set = CS_ASCII;
		inv_mode = 0;
		esc_cnt = 0;
		use_gaps = 1;
		hold_req = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		reg_write(REG_ENABLE, 1);

		// 80 x 30 after reset
		dir = '{
			'{"A", 1, typed_cmd(CMD_DRAW, 8'h41, 0, 0)},
			'{8'hff, 1, typed_cmd(CMD_DRAW, 8'hff, 1, 0)},
			'{CH_CR, 0, '0}, '{CH_LF, 0, '0},
			'{CH_BS, 0, '0},
			'{8'h00, 1, typed_cmd(CMD_DRAW, 8'h00, 79, 0)},
			'{CH_ESC, 0, '0}, '{"[", 0, '0}, '{"6", 0, '0},
			'{"n", 1, typed_cmd(CMD_REPORT, 0, 1, 2)},
			'{CH_ESC, 0, '0}, '{"(", 0, '0}, '{"0", 0, '0},
			'{"q", 1, typed_cmd(CMD_DRAW, 8'hc4, 0, 1)},
			'{CH_ESC, 0, '0}, '{"[", 0, '0}, '{"2", 0, '0},
			'{"J", 1, typed_cmd(CMD_CLEAR, 0, 0, 0)},
			'{CH_ESC, 0, '0}, '{"[", 0, '0}, '{"7", 0, '0}, '{"m", 0, '0},
			'{"B", 0, '0}, '{CH_ESC, 0, '0}, '{"x", 0, '0}
		};
		foreach (dir[i]) send_char(dir[i].ch, dir[i].typed, dir[i].want);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			reg_write(REG_ENABLE, cfg_en[ph]);
			reg_write(REG_COLUMNS, cfg_cols[ph]);
			reg_write(REG_ROWS, cfg_rows[ph]);
			use_gaps = ph != 2;
			if (ph == 1) hold_req = 1;
			start = chars_sent;
			while (chars_sent - start < (cfg_en[ph] ? 150 : 30)) send_piece();
			drain();
		end

		while (expected_cmds.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		failed = mismatches != 0 || expected_cmds.size() != 0;
		$display("run: %0d chars sent (%0d while disabled), %0d command words checked",
			chars_sent, idle_words, words_seen);
		$display("draw %0d scroll %0d clear %0d report %0d show %0d hide %0d, %0d mismatches",
			cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4], cmd_seen[5],
			mismatches);
		if (!failed) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- vt100_text_console_parser_unit.f -----
design/vtp_pkg.sv
design/vtp_ofifo.sv
design/vtp_ctrl.sv
design/vtp_dpath.sv
design/vt100_text_console_parser_unit.sv
bench/tb_vt100_text_console_parser_unit.sv
